// ----- hw/rtl/ldr_pkg.sv -----
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared constants and control types for the longest distinct run block.
// ----------------------------------------------------------------------------
`default_nettype none

package ldr_pkg;

    localparam int SYMBOL_BITS   = 10;
    localparam int POSITION_BITS = 16;
    // generation tag kept with each table entry; a wrap forces a clearing sweep
    localparam int EPOCH_BITS    = 8;
    localparam int RESULT_BITS   = 16;

    // control from the pipeline to the position table
    typedef struct packed {
        logic rd_en;    // request accepted: read the table at its symbol
        logic commit;   // request in the work stage moves on: write its entry
        logic seq_end;  // committed request closes its sequence
    } tbl_ctrl_t;

    // status from the position table
    typedef struct packed {
        logic busy;        // clearing sweep in progress
        logic epoch_last;  // next sequence end wraps the epoch
    } tbl_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ldr_table.sv -----
// ----------------------------------------------------------------------------
// ldr_table
// Last-seen position per symbol, tagged with a sequence epoch, with a
// registered read, write-to-read forwarding and a clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module ldr_table #(
    parameter int SYMBOL_BITS   = ldr_pkg::SYMBOL_BITS,
    parameter int POSITION_BITS = ldr_pkg::POSITION_BITS,
    parameter int EPOCH_BITS    = ldr_pkg::EPOCH_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ldr_pkg::tbl_ctrl_t       ctrl,
    input  wire logic [SYMBOL_BITS-1:0]   rd_sym,
    input  wire logic [SYMBOL_BITS-1:0]   wr_sym,
    input  wire logic [POSITION_BITS-1:0] wr_pos,
    output ldr_pkg::tbl_status_t          status,
    output logic                          hit,
    output logic [POSITION_BITS-1:0]      hit_pos
);

    localparam int DEPTH   = 1 << SYMBOL_BITS;
    localparam int ENTRY_W = 1 + EPOCH_BITS + POSITION_BITS;

    logic [ENTRY_W-1:0]     mem [DEPTH];
    logic [ENTRY_W-1:0]     rdata_reg;
    logic [ENTRY_W-1:0]     fwd_entry_reg;
    logic                   fwd_reg;
    logic [EPOCH_BITS-1:0]  epoch_reg;
    logic [EPOCH_BITS-1:0]  epoch_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic [SYMBOL_BITS-1:0] clr_idx_reg;
    logic [SYMBOL_BITS-1:0] clr_idx_next;

    logic [ENTRY_W-1:0]     wr_entry;
    logic [ENTRY_W-1:0]     entry;
    logic                   we;
    logic [SYMBOL_BITS-1:0] waddr;
    logic [ENTRY_W-1:0]     wdata;
    logic                   wrap;

    assign wr_entry = {1'b1, epoch_reg, wr_pos};
    assign wrap     = ctrl.commit && ctrl.seq_end && (&epoch_reg);

    // sweep and item writes never overlap: no request enters during the sweep
    assign we    = busy_reg || ctrl.commit;
    assign waddr = busy_reg ? clr_idx_reg : wr_sym;
    assign wdata = busy_reg ? '0 : wr_entry;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg     <= mem[rd_sym];
            fwd_entry_reg <= wr_entry;
        end
    end

    always_comb
    begin
        epoch_next   = epoch_reg;
        busy_next    = busy_reg;
        clr_idx_next = clr_idx_reg;
        if (ctrl.commit && ctrl.seq_end)
        begin
            epoch_next = epoch_reg + 1'b1;
        end
        if (busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (&clr_idx_reg)
            begin
                busy_next = 1'b0;
            end
        end
        else if (wrap)
        begin
            busy_next    = 1'b1;
            clr_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg   <= '0;
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            epoch_reg   <= epoch_next;
            busy_reg    <= busy_next;
            clr_idx_reg <= clr_idx_next;
            // the memory read misses a write landing in the same cycle
            if (ctrl.rd_en)
            begin
                fwd_reg <= ctrl.commit && (wr_sym == rd_sym);
            end
        end
    end

    assign entry   = fwd_reg ? fwd_entry_reg : rdata_reg;
    assign hit     = entry[ENTRY_W-1] &&
                     (entry[POSITION_BITS +: EPOCH_BITS] == epoch_reg);
    assign hit_pos = entry[POSITION_BITS-1:0];

    assign status.busy       = busy_reg;
    assign status.epoch_last = &epoch_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ldr_scan.sv -----
// ----------------------------------------------------------------------------
// ldr_scan
// Window state: position counter, current and best run, overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ldr_scan #(
    parameter int POSITION_BITS = ldr_pkg::POSITION_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            step,
    input  wire logic                            last,
    input  wire logic                            hit,
    input  wire logic [POSITION_BITS-1:0]        hit_pos,
    output logic      [POSITION_BITS-1:0]        position,
    output logic      [ldr_pkg::RESULT_BITS-1:0] current_run,
    output logic      [ldr_pkg::RESULT_BITS-1:0] best_run,
    output logic                                 overflow
);

    localparam int RUN_W = POSITION_BITS + 1;
    localparam int RES_W = ldr_pkg::RESULT_BITS;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [RUN_W-1:0]         run_reg;
    logic [RUN_W-1:0]         run_next;
    logic [RUN_W-1:0]         best_reg;
    logic [RUN_W-1:0]         best_next;
    logic                     ovf_reg;
    logic                     ovf_next;

    logic [POSITION_BITS-1:0] distance;
    logic                     repeat_hit;
    logic [RUN_W-1:0]         run_now;
    logic [RUN_W-1:0]         best_now;

    assign distance   = pos_reg - hit_pos;
    assign repeat_hit = hit && (distance != '0) && ({1'b0, distance} <= run_reg);

    always_comb
    begin
        if (repeat_hit)
        begin
            run_now = {1'b0, distance};
        end
        else if (!run_reg[POSITION_BITS])
        begin
            run_now = run_reg + 1'b1;
        end
        else
        begin
            run_now = run_reg;
        end
        best_now = (run_now > best_reg) ? run_now : best_reg;
    end

    always_comb
    begin
        pos_next  = pos_reg + 1'b1;
        ovf_next  = ovf_reg || (&pos_reg);
        run_next  = run_now;
        best_next = best_now;
        if (last)
        begin
            pos_next  = '0;
            ovf_next  = 1'b0;
            run_next  = '0;
            best_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            run_reg  <= '0;
            best_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            run_reg  <= run_next;
            best_reg <= best_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign position    = pos_reg;
    // clip to the result width
    assign current_run = (run_now > RUN_W'(17'h0FFFF)) ? {RES_W{1'b1}} : RES_W'(run_now);
    assign best_run    = (best_now > RUN_W'(17'h0FFFF)) ? {RES_W{1'b1}} : RES_W'(best_now);
    assign overflow    = ovf_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/longest_distinct_run.sv -----
// Path: accepted requests pass the input stage, then the result register (m_tvalid).
// Throughput: one request per cycle, set by the single table read/write per symbol,
// while the output does not stall and no sweep runs.
// Reset: all control state clears; the position table then runs a clearing sweep of
// all 2^SYMBOL_BITS entries with s_tready low. The same sweep follows every
// 2^EPOCH_BITS-th sequence end, when the sequence epoch tag wraps.
// ----------------------------------------------------------------------------
// longest_distinct_run
// Streams symbols and reports the current and longest run of distinct symbols.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_distinct_run #(
    parameter int SYMBOL_BITS   = ldr_pkg::SYMBOL_BITS,
    parameter int POSITION_BITS = ldr_pkg::POSITION_BITS,
    parameter int EPOCH_BITS    = ldr_pkg::EPOCH_BITS,
    localparam int S_TDATA_W    = ((SYMBOL_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W    = 2 * ldr_pkg::RESULT_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // symbol
    input  wire logic                 s_tlast,   // end_of_sequence
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // current_run, best_run
    output logic                      m_tlast,   // sequence_done
    output logic                      m_tuser    // overflow
);

    localparam int RES_W = ldr_pkg::RESULT_BITS;

    logic                     a_valid_reg;
    logic [SYMBOL_BITS-1:0]   a_sym_reg;
    logic                     a_last_reg;
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;
    logic                     m_last_reg;
    logic                     m_user_reg;

    logic                     s_accept;
    logic                     a_adv;
    ldr_pkg::tbl_ctrl_t       tbl_ctrl;
    ldr_pkg::tbl_status_t     tbl_status;
    logic                     hit;
    logic [POSITION_BITS-1:0] hit_pos;
    logic [POSITION_BITS-1:0] position;
    logic [RES_W-1:0]         current_run;
    logic [RES_W-1:0]         best_run;
    logic                     overflow;

    assign a_adv    = a_valid_reg && (!m_valid_reg || m_tready);
    // hold off the request behind an epoch wrap until the sweep has run
    assign s_tready = !tbl_status.busy &&
                      (!a_valid_reg ||
                       (a_adv && !(a_last_reg && tbl_status.epoch_last)));
    assign s_accept = s_tvalid && s_tready;

    assign tbl_ctrl.rd_en   = s_accept;
    assign tbl_ctrl.commit  = a_adv;
    assign tbl_ctrl.seq_end = a_last_reg;

    ldr_table #(
        .SYMBOL_BITS   (SYMBOL_BITS),
        .POSITION_BITS (POSITION_BITS),
        .EPOCH_BITS    (EPOCH_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tbl_ctrl),
        .rd_sym  (s_tdata[SYMBOL_BITS-1:0]),
        .wr_sym  (a_sym_reg),
        .wr_pos  (position),
        .status  (tbl_status),
        .hit     (hit),
        .hit_pos (hit_pos)
    );

    ldr_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (a_adv),
        .last        (a_last_reg),
        .hit         (hit),
        .hit_pos     (hit_pos),
        .position    (position),
        .current_run (current_run),
        .best_run    (best_run),
        .overflow    (overflow)
    );

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_sym_reg  <= s_tdata[SYMBOL_BITS-1:0];
            a_last_reg <= s_tlast;
        end
        if (a_adv)
        begin
            m_data_reg <= {best_run, current_run};
            m_last_reg <= a_last_reg;
            m_user_reg <= overflow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_sweep_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n) tbl_status.busy |-> !s_tready
    ) else $error("request accepted during table sweep");

    a_accept_fills_stage: assert property (
        @(posedge clk) disable iff (!rst_n) s_accept |=> a_valid_reg
    ) else $error("accepted request lost from work stage");

    a_advance_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n) a_adv |=> m_tvalid
    ) else $error("advanced request produced no result");

    a_best_covers_current: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:RES_W] >= m_tdata[RES_W-1:0])
    ) else $error("best run below current run");

endmodule

`default_nettype wire
